// ===== sv/sitoa_pkg.sv =====
`timescale 1ns / 1ps

package sitoa_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int MAX_DIGITS = 10;
    localparam int COUNT_W = $clog2(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // ceil(2^35 / 10), exact quotient for every 32-bit unsigned dividend
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    typedef logic [VALUE_W-1:0] mag_t;
    typedef logic [DIGIT_W-1:0] digit_t;

endpackage

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII text.
// Input channel s_*: one transaction carries s_value (two's complement).
// Output channel m_*: one transaction per character, most significant first;
// m_ascii_char is '-' or '0'..'9', m_is_last marks the final character.
// A number yields 1 to 11 output transactions; no terminator is sent.
// After accept, the digit loop produces one decimal digit per cycle (nd = 1..10)
// through a single divide-by-ten unit (reciprocal multiply); the digits are then
// sent out one per cycle while the receiver takes them, most significant first.
// A minus sign goes out in the digit loop if the output is free, else before the digits.
// s_ready is high only while the sequencer is idle; the next number can be
// accepted while the final character still sits in the output register.
// If the receiver stalls, the output register holds its character and the
// emit phase waits; nothing is dropped or repeated.
// Reset (aresetn low at a clock edge) returns the sequencer to idle and
// empties the output register; a number in flight is discarded.

module signed_int_to_decimal_ascii_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sitoa_pkg::VALUE_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sitoa_pkg::CHAR_W-1:0]      m_ascii_char,
    output logic                              m_is_last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    sitoa_pkg::mag_t mag_reg, mag_next;
    logic [sitoa_pkg::COUNT_W-1:0] nd_reg, nd_next;
    logic [sitoa_pkg::COUNT_W-1:0] idx_reg, idx_next;
    logic sign_pend_reg, sign_pend_next;

    sitoa_pkg::digit_t digit_reg [sitoa_pkg::MAX_DIGITS];
    logic digit_we;

    logic m_valid_reg, m_valid_next;
    logic [sitoa_pkg::CHAR_W-1:0] char_reg, char_next;
    logic last_reg, last_next;

    sitoa_pkg::mag_t   quotient;
    sitoa_pkg::digit_t remainder;

    logic out_free;
    logic out_load;

    sitoa_div10 u_div10 (
        .dividend  (mag_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_ascii_char = char_reg;
    assign m_is_last    = last_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        nd_next        = nd_reg;
        idx_next       = idx_reg;
        sign_pend_next = sign_pend_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_load       = 1'b0;
        digit_we       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sign_pend_next = s_value[sitoa_pkg::VALUE_W-1];
                    // unsigned negate covers the most negative value too
                    mag_next = s_value[sitoa_pkg::VALUE_W-1]
                             ? sitoa_pkg::mag_t'(-s_value)
                             : sitoa_pkg::mag_t'(s_value);
                    nd_next    = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                digit_we = 1'b1;
                nd_next  = nd_reg + 1'b1;
                mag_next = quotient;
                if (quotient == '0) begin
                    idx_next   = nd_reg;
                    state_next = ST_EMIT;
                end
                // sign goes out while digits are still being produced
                if (out_free && sign_pend_reg) begin
                    out_load       = 1'b1;
                    char_next      = sitoa_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    sign_pend_next = 1'b0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (sign_pend_reg) begin
                        char_next      = sitoa_pkg::CHAR_MINUS;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end else begin
                        char_next = sitoa_pkg::CHAR_ZERO
                                  + {{(sitoa_pkg::CHAR_W-sitoa_pkg::DIGIT_W){1'b0}},
                                     digit_reg[idx_reg]};
                        last_next = (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sign_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            nd_reg        <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            sign_pend_reg <= sign_pend_next;
            m_valid_reg   <= m_valid_next;
            nd_reg        <= nd_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (digit_we) begin
            digit_reg[nd_reg] <= remainder;
        end
    end

    a_accept_starts_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CONV))
        else $error("accepted transaction did not start the digit loop");

    a_no_sign_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sign_pend_reg)
        else $error("minus sign still pending in idle");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_ascii_char == sitoa_pkg::CHAR_MINUS)) |-> !m_is_last)
        else $error("minus sign flagged as last character");

    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (nd_reg != '0) && (idx_reg < nd_reg))
        else $error("emit index outside produced digits");

    a_digit_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> (nd_reg < sitoa_pkg::MAX_DIGITS))
        else $error("digit loop ran past ten digits");

endmodule

// ===== sv/sitoa_div10.sv =====
`timescale 1ns / 1ps

module sitoa_div10 (
    input  sitoa_pkg::mag_t   dividend,
    output sitoa_pkg::mag_t   quotient,
    output sitoa_pkg::digit_t remainder
);

    logic [2*sitoa_pkg::VALUE_W-1:0] product;
    sitoa_pkg::mag_t                 times_ten;
    sitoa_pkg::mag_t                 diff;

    // reciprocal multiply, then remainder from quotient * 10 as shift-add
    assign product   = {{sitoa_pkg::VALUE_W{1'b0}}, dividend}
                     * {{sitoa_pkg::VALUE_W{1'b0}}, sitoa_pkg::RECIP_TEN};
    assign quotient  = sitoa_pkg::mag_t'(product >> sitoa_pkg::RECIP_SHIFT);
    assign times_ten = (quotient << 3) + (quotient << 1);
    assign diff      = dividend - times_ten;
    assign remainder = diff[sitoa_pkg::DIGIT_W-1:0];

endmodule
